// File: sv/lfu_cache_table_assert.svh
// Assertion macros used by the cache table RTL.
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define LCT_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A cause that is followed by an effect in the next cycle.
`define LCT_ASSERT_NEXT(label, cause, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cause) |=> (effect)) else $error(msg);

`endif

// File: sv/lct_pkg.sv
package lct_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int RANK_W  = $clog2(ENTRIES);
	localparam int OCC_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int KEY_W   = 32;
	localparam int DATA_W  = 31;
	localparam int CNT_W   = 32;

	// Commands broadcast to every cell.
	localparam logic [1:0] CMD_NONE   = 2'd0;
	localparam logic [1:0] CMD_TOUCH  = 2'd1;
	localparam logic [1:0] CMD_EVICT  = 2'd2;
	localparam logic [1:0] CMD_INSERT = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic              wr_data;
		logic [RANK_W-1:0] ref_rank;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} cell_cmd_t;

	// Running victim candidate handed from cell to cell.
	typedef struct packed {
		logic              vld;
		logic [CNT_W-1:0]  cnt;
		logic [RANK_W-1:0] rank;
		logic [IDX_W-1:0]  idx;
	} cand_t;

endpackage

// File: sv/lct_cell.sv
module lct_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lct_pkg::IDX_W-1:0]     idx,
	input  lct_pkg::cell_cmd_t            cmd,
	input  logic                          sel,
	input  lct_pkg::cand_t                cand_in,
	output lct_pkg::cand_t                cand_out,
	output logic                          valid,
	output logic                          match,
	output logic [lct_pkg::RANK_W-1:0]    rank,
	output logic [lct_pkg::DATA_W-1:0]    data
);
	import lct_pkg::*;

	logic              valid_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] data_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RANK_W-1:0] rank_q;
	cand_t             cand_q;
	cand_t             cand_nxt;
	logic              better;

	assign valid = valid_q;
	assign match = valid_q && (key_q == cmd.key);
	assign rank  = rank_q;
	assign data  = data_q;
	assign cand_out = cand_q;

	// This entry beats the incoming candidate on lower count, then on older touch.
	always_comb begin
		better = valid_q && (!cand_in.vld || (cnt_q < cand_in.cnt) ||
			((cnt_q == cand_in.cnt) && (rank_q > cand_in.rank)));
		if (better) begin
			cand_nxt = '{vld: 1'b1, cnt: cnt_q, rank: rank_q, idx: idx};
		end else begin
			cand_nxt = cand_in;
		end
	end

	// Control state: the valid bit and the candidate stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cand_q  <= '0;
		end else begin
			cand_q <= cand_nxt;
			case (cmd.op)
				CMD_EVICT: if (sel) valid_q <= 1'b0;
				CMD_INSERT: if (sel) valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Entry payload, count and recency rank.
	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_TOUCH: begin
				if (sel) begin
					if (cnt_q != {CNT_W{1'b1}}) cnt_q <= cnt_q + 1'b1;
					rank_q <= '0;
					if (cmd.wr_data) data_q <= cmd.data;
				end else if (valid_q && (rank_q < cmd.ref_rank)) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			CMD_EVICT: begin
				if (!sel && valid_q && (rank_q > cmd.ref_rank)) rank_q <= rank_q - 1'b1;
			end
			CMD_INSERT: begin
				if (sel) begin
					key_q  <= cmd.key;
					data_q <= cmd.data;
					cnt_q  <= CNT_W'(1);
					rank_q <= '0;
				end else if (valid_q) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: sv/lfu_cache_table.sv
// Channel   Direction  Fields
// s_axis    in         tuser: operation; tdata: lookup_key, write_value
// m_axis    out        tuser: hit; tdata: read_value
// cfg       in         data: capacity
//
// A hit or a plain miss passes from the lookup state straight to the done state.
// An insert without eviction adds the insert state; an insert with eviction first
// scans, the victim candidate walking the row of cells one cell per cycle, then evicts and inserts.
// One item is in work at a time; a result waits in the output register while
// the next item is accepted. Reset clears all entries and sets capacity to 16.
module lfu_cache_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [63:0]                  s_axis_tdata,  // lookup_key[31:0], write_value[62:32]
	input  logic                         s_axis_tuser,  // operation
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [31:0]                  m_axis_tdata,  // read_value[30:0]
	output logic                         m_axis_tuser,  // hit
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lct_pkg::CAP_W-1:0]    cfg_data
);
	import lct_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOK   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_EVICT  = 3'd3;
	localparam logic [2:0] ST_INSERT = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]        state_q;
	logic [CAP_W-1:0]  cap_q;
	logic [OCC_W-1:0]  occ_q;
	logic [IDX_W-1:0]  scan_q;
	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] val_q;
	logic              hit_q;
	logic [DATA_W-1:0] rd_q;
	logic              out_valid_q;
	logic              out_hit_q;
	logic [DATA_W-1:0] out_data_q;

	cell_cmd_t          cmd;
	logic [ENTRIES-1:0] sel_vec;
	logic [ENTRIES-1:0] valid_vec;
	logic [ENTRIES-1:0] match_vec;
	logic [RANK_W-1:0]  rank_arr [ENTRIES];
	logic [DATA_W-1:0]  data_arr [ENTRIES];
	cand_t              cand_arr [ENTRIES+1];
	logic [RANK_W-1:0]  hit_rank;
	logic [DATA_W-1:0]  hit_data;
	logic [ENTRIES-1:0] free_sel;
	logic               free_found;
	logic [OCC_W-1:0]   cap_eff;
	logic               any_hit;
	logic               out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_hit_q;
	assign m_axis_tdata  = {1'b0, out_data_q};
	assign out_free      = !out_valid_q || m_axis_tready;
	assign any_hit       = |match_vec;
	assign cap_eff = (cap_q > CAP_W'(ENTRIES)) ? OCC_W'(ENTRIES) : OCC_W'(cap_q);
	assign cand_arr[0] = '0;

	// Row of cells; the candidate chain runs from cell 0 upward.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lct_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (IDX_W'(i)),
			.cmd      (cmd),
			.sel      (sel_vec[i]),
			.cand_in  (cand_arr[i]),
			.cand_out (cand_arr[i+1]),
			.valid    (valid_vec[i]),
			.match    (match_vec[i]),
			.rank     (rank_arr[i]),
			.data     (data_arr[i])
		);
	end

	// Rank and data of the matching entry, and the lowest free slot.
	always_comb begin
		hit_rank   = '0;
		hit_data   = '0;
		free_sel   = '0;
		free_found = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_vec[i]) begin
				hit_rank = hit_rank | rank_arr[i];
				hit_data = hit_data | data_arr[i];
			end
			if (!valid_vec[i] && !free_found) begin
				free_sel[i] = 1'b1;
				free_found  = 1'b1;
			end
		end
	end

	// Command broadcast to the cells for the current step.
	always_comb begin
		cmd.op       = CMD_NONE;
		cmd.wr_data  = op_q;
		cmd.ref_rank = hit_rank;
		cmd.key      = key_q;
		cmd.data     = val_q;
		sel_vec      = match_vec;
		case (state_q)
			ST_LOOK: begin
				if (any_hit && (!op_q || (cap_eff != '0))) cmd.op = CMD_TOUCH;
			end
			ST_EVICT: begin
				cmd.op       = CMD_EVICT;
				cmd.ref_rank = cand_arr[ENTRIES].rank;
				sel_vec      = '0;
				sel_vec[cand_arr[ENTRIES].idx] = cand_arr[ENTRIES].vld;
			end
			ST_INSERT: begin
				cmd.op  = CMD_INSERT;
				sel_vec = free_sel;
			end
			default: ;
		endcase
	end

	// Item registers, loaded on the input transfer, and the lookup result, taken in the lookup state.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q  <= s_axis_tuser;
			key_q <= s_axis_tdata[31:0];
			val_q <= s_axis_tdata[62:32];
		end
		if (state_q == ST_LOOK) begin
			hit_q <= any_hit;
			rd_q  <= (any_hit && !op_q) ? hit_data : '0;
		end
	end

	// Sequencer, occupancy, configuration and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_W'(16);
			occ_q       <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) cap_q <= cfg_data;
			// The output register takes a finished result, or empties on a transfer.
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
				out_hit_q   <= hit_q;
				out_data_q  <= rd_q;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					scan_q <= '0;
					if (!any_hit && op_q && (cap_eff != '0)) begin
						state_q <= (occ_q >= cap_eff) ? ST_SCAN : ST_INSERT;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == IDX_W'(ENTRIES - 1)) state_q <= ST_EVICT;
				end
				ST_EVICT: begin
					if (cand_arr[ENTRIES].vld) occ_q <= occ_q - 1'b1;
					state_q <= ST_INSERT;
				end
				ST_INSERT: begin
					if (free_found) occ_q <= occ_q + 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "lfu_cache_table_assert.svh"

	`LCT_ASSERT_ALWAYS(a_one_match, $onehot0(match_vec), "key stored in two entries")
	`LCT_ASSERT_ALWAYS(a_occ_count, $countones(valid_vec) == occ_q, "occupancy out of step")
	`LCT_ASSERT_NEXT(a_scan_evict, (state_q == ST_SCAN) && (scan_q == IDX_W'(ENTRIES - 1)), (state_q == ST_EVICT) && cand_arr[ENTRIES].vld, "no victim found after scan")
	`LCT_ASSERT_NEXT(a_done_load, (state_q == ST_DONE) && out_free, out_valid_q, "result not loaded")

endmodule
